FILE: design/scpq_pkg.sv
`timescale 1ns / 1ps

package scpq_pkg;

   localparam int PRIO_W = 8;
   localparam int TAG_W  = 16;
   localparam int CNT_W  = 5;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      MODE_ENQ = 1'b0,
      MODE_DEQ = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef logic [CAP_W-1:0] cap_type;

   typedef struct packed {
      mode_type          mode;
      logic [PRIO_W-1:0] priority_req;
      logic [TAG_W-1:0]  payload;
   } req_type;

   typedef struct packed {
      logic              data_valid;
      logic [PRIO_W-1:0] out_priority;
      logic [TAG_W-1:0]  out_payload;
      status_type        status;
      logic [CNT_W-1:0]  count;
      logic              empty_res;
   } rsp_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } slot_type;

endpackage

FILE: design/scpq_chan_if.sv
`timescale 1ns / 1ps

interface scpq_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/scpq_ram.sv
`timescale 1ns / 1ps

module scpq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/scpq_seq.sv
`timescale 1ns / 1ps

module scpq_seq
   import scpq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   scpq_chan_if.sink        req_if,
   input  logic [CAP_W-1:0] cap_eff,
   input  logic             clear,
   output logic             idle,
   output logic             res_valid,
   input  logic             res_ready,
   output rsp_type          res
);

   localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
   localparam int SW      = $clog2(CAP_MAX);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_INSERT,
      S_DEQ,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [SW-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [SW-1:0]     ptr_ff, ptr_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   rsp_type           res_ff, res_in;

   logic                     ram_we;
   logic [SW-1:0]            ram_wa;
   logic [$bits(slot_type)-1:0] ram_wd;
   logic                     ram_re;
   logic [SW-1:0]            ram_ra;
   logic [$bits(slot_type)-1:0] ram_rd;
   slot_type                 rd_slot;

   logic [SW-1:0]  enq_head;
   logic [5:0]     enq_sum;
   logic [SW-1:0]  enq_ptr;
   logic [SW-1:0]  src_idx;
   logic [SW-1:0]  head_next;

   function automatic logic [SW-1:0] wrap_dec(input logic [SW-1:0] x,
                                              input logic [CAP_W-1:0] c);
      logic [CAP_W-1:0] top;
      top = c - 5'd1;
      return (x == '0) ? SW'(top) : x - SW'(1);
   endfunction

   assign rd_slot  = slot_type'(ram_rd);
   assign enq_head = (count_ff == '0) ? '0 : head_ff;
   assign enq_sum  = 6'(enq_head) + 6'(count_ff);
   // head plus count stays below twice the capacity
   assign enq_ptr  = (enq_sum >= 6'(cap_eff)) ? SW'(enq_sum - 6'(cap_eff)) : SW'(enq_sum);
   assign src_idx  = wrap_dec(ptr_ff, cap_eff);
   assign head_next = ((5'(head_ff) + 5'd1) == cap_eff) ? '0 : head_ff + SW'(1);

   assign idle         = (state_ff == S_IDLE);
   assign req_if.ready = (state_ff == S_IDLE) && !clear;
   assign res_valid    = (state_ff == S_DONE);
   assign res          = res_ff;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      k_in     = k_ff;
      ptr_in   = ptr_ff;
      prio_in  = prio_ff;
      tag_in   = tag_ff;
      res_in   = res_ff;
      ram_we   = 1'b0;
      ram_wa   = ptr_ff;
      ram_wd   = {prio_ff, tag_ff};
      ram_re   = 1'b0;
      ram_ra   = src_idx;
      case (state_ff)
         S_IDLE: begin
            if (clear) begin
               head_in  = '0;
               count_in = '0;
            end else if (req_if.valid) begin
               prio_in = req_if.data.priority_req;
               tag_in  = req_if.data.payload;
               res_in  = '0;
               res_in.count     = count_ff;
               res_in.empty_res = (count_ff == '0);
               if (req_if.data.mode == MODE_ENQ) begin
                  if (count_ff >= cap_eff) begin
                     res_in.status = STATUS_FULL;
                     state_in      = S_DONE;
                  end else begin
                     head_in = enq_head;
                     k_in    = count_ff;
                     ptr_in  = enq_ptr;
                     if (count_ff == '0) begin
                        state_in = S_INSERT;
                     end else begin
                        ram_re   = 1'b1;
                        ram_ra   = wrap_dec(enq_ptr, cap_eff);
                        state_in = S_SHIFT;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status = STATUS_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     ram_re   = 1'b1;
                     ram_ra   = head_ff;
                     state_in = S_DEQ;
                  end
               end
            end
         end
         S_SHIFT: begin
            // strictly larger priorities move back one slot
            if (prio_ff < rd_slot.prio) begin
               ram_we = 1'b1;
               ram_wa = ptr_ff;
               ram_wd = ram_rd;
               ptr_in = src_idx;
               k_in   = k_ff - 5'd1;
               if (k_ff == 5'd1) begin
                  state_in = S_INSERT;
               end else begin
                  ram_re = 1'b1;
                  ram_ra = wrap_dec(src_idx, cap_eff);
               end
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            ram_we   = 1'b1;
            count_in = count_ff + 5'd1;
            res_in.status    = STATUS_DONE;
            res_in.count     = count_ff + 5'd1;
            res_in.empty_res = 1'b0;
            state_in = S_DONE;
         end
         S_DEQ: begin
            res_in.data_valid   = 1'b1;
            res_in.out_priority = rd_slot.prio;
            res_in.out_payload  = rd_slot.tag;
            res_in.status       = STATUS_DONE;
            res_in.count        = count_ff - 5'd1;
            res_in.empty_res    = (count_ff == 5'd1);
            count_in = count_ff - 5'd1;
            head_in  = (count_ff == 5'd1) ? '0 : head_next;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      k_ff    <= k_in;
      ptr_ff  <= ptr_in;
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
      res_ff  <= res_in;
   end

   scpq_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (CAP_MAX)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   a_count_in_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_eff)
      else $error("entry count above capacity");

   a_head_in_cap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (5'(head_ff) < cap_eff))
      else $error("head index outside capacity");

   a_shift_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (k_ff != '0 && count_ff != '0))
      else $error("shift step with nothing left to move");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_wa != ram_ra))
      else $error("slot read and written in the same cycle");

   a_deq_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DEQ) |-> (count_ff != '0))
      else $error("dequeue read from an empty queue");

endmodule

FILE: design/sorted_circular_priority_queue.sv
`timescale 1ns / 1ps

// sorted priority queue in a circular slot buffer, smallest priority value first
// req_if carries one request: mode (enqueue or dequeue), priority_req and payload
// rsp_if returns one response per request: the dequeued entry if any, a status
// code (done, full on enqueue, empty on dequeue), the count and the empty flag
// csr_if writes the capacity register (1..16 slots in use, 0 acts as 1, larger
// values saturate); a write empties the queue and is taken only while idle
// one request is in flight at a time; req_if.ready is high only while idle
// enqueue walks back from the tail: each stored entry with a strictly larger
// priority moves back one slot (at most count entries), and the walk stops at
// the first entry that stays; each walk step reads one slot of the two-port
// slot RAM and writes the slot after it
// reset empties the queue and sets the capacity to 16; slot contents are not
// cleared, only slots holding live entries are ever read
// the response sits in an output register; if rsp_if stalls, the finished
// request waits in the sequencer and no new request is taken until it moves on
module sorted_circular_priority_queue
   import scpq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   scpq_chan_if.sink    req_if,
   scpq_chan_if.source  rsp_if,
   scpq_chan_if.sink    csr_if
);

   localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_eff;
   logic             seq_idle;
   logic             cap_write;
   logic             res_valid;
   logic             res_ready;
   rsp_type          res;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   assign csr_if.ready = seq_idle;
   assign cap_write    = csr_if.valid && seq_idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (cap_write) begin
         cap_ff <= csr_if.data;
      end
   end

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = 5'd1;
      end else if (32'(cap_ff) > CAP_MAX) begin
         cap_eff = 5'(CAP_MAX);
      end else begin
         cap_eff = cap_ff;
      end
   end

   scpq_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cap_eff   (cap_eff),
      .clear     (cap_write),
      .idle      (seq_idle),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

FILE: verif/scpq_checker.sv
`timescale 1ns / 1ps

module scpq_checker
   import scpq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  cap_type csr_data,
   output int      mismatches,
   output int      awaiting
);

   slot_type    slot_mem [DEPTH];
   int unsigned head_slot;
   int unsigned held;
   int unsigned cap_setting;
   rsp_type     expected_rsp_q [$];

   function automatic int unsigned active_slots();
      if (cap_setting == 0) return 1;
      if (cap_setting > DEPTH) return DEPTH;
      return cap_setting;
   endfunction

   // applies one request to the shadow queue and returns the response it should produce
   function automatic rsp_type serve_request(req_type r);
      rsp_type     res;
      int unsigned lim;
      int unsigned land;
      int unsigned k;
      int unsigned src;
      int unsigned dst;
      lim = active_slots();
      res = '0;
      res.status = STATUS_DONE;
      if (head_slot >= lim) head_slot = head_slot % lim;
      if (held > lim) held = lim;
      if (r.mode == MODE_ENQ) begin
         if (held >= lim) begin
            res.status = STATUS_FULL;
         end else begin
            if (held == 0) head_slot = 0;
            land = held;
            // walk back from the tail, moving strictly larger priorities one slot on
            for (k = held; k > 0; k--) begin
               src = (head_slot + k - 1) % lim;
               dst = (head_slot + k) % lim;
               if (r.priority_req >= slot_mem[src].prio) break;
               slot_mem[dst] = slot_mem[src];
               land = k - 1;
            end
            slot_mem[(head_slot + land) % lim] = '{prio: r.priority_req, tag: r.payload};
            held++;
         end
      end else if (held == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.data_valid   = 1'b1;
         res.out_priority = slot_mem[head_slot].prio;
         res.out_payload  = slot_mem[head_slot].tag;
         held--;
         head_slot = (held == 0) ? 0 : (head_slot + 1) % lim;
      end
      res.count     = CNT_W'(held);
      res.empty_res = (held == 0);
      return res;
   endfunction

   function automatic string describe(rsp_type r);
      return $sformatf("valid=%0d prio=%0d payload=%h status=%0d count=%0d empty=%0d",
                       r.data_valid, r.out_priority, r.out_payload, r.status, r.count,
                       r.empty_res);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head_slot   = 0;
         held        = 0;
         cap_setting = CAP_RESET;
         mismatches  = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no request waiting: %s", $time,
                           describe(rsp_data));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.data_valid !== want.data_valid ||
                   rsp_data.out_priority !== want.out_priority ||
                   rsp_data.out_payload !== want.out_payload ||
                   rsp_data.status !== want.status ||
                   rsp_data.count !== want.count ||
                   rsp_data.empty_res !== want.empty_res) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: response mismatch", $time);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(rsp_data));
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            cap_setting = csr_data;
            head_slot   = 0;
            held        = 0;
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(serve_request(req_data));
      end
      awaiting = expected_rsp_q.size();
   end

endmodule

FILE: verif/tb_sorted_circular_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_circular_priority_queue;
   import scpq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int PERIOD       = 12;
   localparam int RESET_CYCLES = 9;
   localparam int GAP_MAX      = 6;
   localparam int STUCK_LIMIT  = 2000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 152;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;
   int   mismatches;
   int   awaiting;
   int   stuck_cycles = 0;

   always #(PERIOD / 2) clock = ~clock;

   scpq_chan_if #(.payload_type(req_type)) req_if ();
   scpq_chan_if #(.payload_type(rsp_type)) rsp_if ();
   scpq_chan_if #(.payload_type(cap_type)) csr_if ();

   sorted_circular_priority_queue #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   scpq_checker #(
      .DEPTH(DEPTH)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_data   (req_if.data),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_data   (rsp_if.data),
      .csr_valid  (csr_if.valid),
      .csr_ready  (csr_if.ready),
      .csr_data   (csr_if.data),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   task automatic send_req(mode_type m, logic [PRIO_W-1:0] p, logic [TAG_W-1:0] t);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.data  <= '{mode: m, priority_req: p, payload: t};
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      wait (awaiting == 0);
      @(negedge clock);
   endtask

   task automatic write_capacity(cap_type c);
      drain();
      csr_if.data  <= c;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // mix of tie-heavy, full-range and near-maximum priorities
   function automatic logic [PRIO_W-1:0] draw_priority();
      case ($urandom_range(0, 2))
         0: return PRIO_W'($urandom_range(0, 3));
         1: return PRIO_W'($urandom);
         default: return PRIO_W'($urandom_range(250, 255));
      endcase
   endfunction

   // response side
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_sorted_circular_priority_queue: FAIL");
            $finish;
         end
      end
   end

   initial begin
      cap_type  phase_caps [8];
      cap_type  cap_pick;
      int       slots;
      int       sent;
      int       run;
      bit       fill_run;
      mode_type m;
      phase_caps = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd3, 5'd17, 5'd16};
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset capacity: empty dequeue, ties kept in arrival order, extremes
      send_req(MODE_DEQ, 8'h00, 16'h0000);
      send_req(MODE_ENQ, 8'd200, 16'hFFFF);
      send_req(MODE_ENQ, 8'd0, 16'h0000);
      send_req(MODE_ENQ, 8'd200, 16'h1234);
      send_req(MODE_ENQ, 8'd100, 16'hA5A5);
      send_req(MODE_ENQ, 8'd255, 16'h5A5A);
      send_req(MODE_ENQ, 8'd200, 16'h0001);
      repeat (7) send_req(MODE_DEQ, 8'hFF, 16'hFFFF);
      // single slot: full and empty
      write_capacity(5'd1);
      send_req(MODE_ENQ, 8'd7, 16'hBEEF);
      send_req(MODE_ENQ, 8'd8, 16'h0F0F);
      send_req(MODE_DEQ, 8'd0, 16'h0000);
      send_req(MODE_DEQ, 8'd0, 16'h0000);
      // zero capacity acts as one slot
      write_capacity(5'd0);
      send_req(MODE_ENQ, 8'd9, 16'h0001);
      send_req(MODE_ENQ, 8'd9, 16'h0002);
      send_req(MODE_DEQ, 8'd0, 16'h0000);

      for (int ph = 0; ph < PHASES; ph++) begin
         cap_pick = (ph < 8) ? phase_caps[ph] : cap_type'($urandom_range(1, DEPTH));
         write_capacity(cap_pick);
         no_idle = (ph % 4 == 3);
         slots = (cap_pick == 0) ? 1 : ((cap_pick > DEPTH) ? DEPTH : int'(cap_pick));
         sent = 0;
         // runs that mostly fill or mostly drain, so full and empty both come up
         while (sent < PHASE_ITEMS) begin
            run = $urandom_range(1, 2 * slots + 1);
            fill_run = $urandom_range(0, 1);
            repeat (run) begin
               m = ((($urandom_range(0, 9) < 8) ? 1'b1 : 1'b0) == fill_run) ?
                   MODE_ENQ : MODE_DEQ;
               send_req(m, draw_priority(), TAG_W'($urandom));
               sent++;
            end
         end
      end
      no_idle = 1'b0;

      drain();
      repeat (25) @(posedge clock);
      if (mismatches == 0 && awaiting == 0) begin
         $display("tb_sorted_circular_priority_queue: PASS");
      end else begin
         $display("tb_sorted_circular_priority_queue: FAIL");
      end
      $finish;
   end

endmodule
